[rtl/murmur3_x64_stream_hash_core_macros.svh]
// Assertion macros for the streaming hash core.
`ifndef MURMUR3_X64_STREAM_HASH_CORE_MACROS_SVH
`define MURMUR3_X64_STREAM_HASH_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, idle during rst.
`define M3X_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, idle during rst.
`define M3X_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/m3x_pkg.sv]
// Shared constants, types and helpers of the streaming hash core.
package m3x_pkg;

  localparam int unsigned LENGTH_BITS_DEF = 31;
  localparam int unsigned ADDR_W = 4;

  localparam logic REG_SEED = 1'b0;
  localparam logic REG_MODE = 1'b1;

  localparam logic [63:0] MUL_A    = 64'h87c3_7b91_1142_53d5;
  localparam logic [63:0] MUL_B    = 64'h4cf5_ad43_2745_937f;
  localparam logic [63:0] ADD_ONE  = 64'h0000_0000_52dc_e729;
  localparam logic [63:0] ADD_TWO  = 64'h0000_0000_3849_5ab5;
  localparam logic [63:0] FIN_A    = 64'hff51_afd7_ed55_8ccd;
  localparam logic [63:0] FIN_B    = 64'hc4ce_b9fe_1a85_ec53;
  localparam logic [63:0] LOW_BITS = 64'h0101_0101_0101_0101;

  localparam logic [4:0] FULL_COUNT = 5'd16;
  localparam logic [4:0] HALF_COUNT = 5'd8;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_S1A,
    ST_S1B,
    ST_T1,
    ST_L1X,
    ST_L1M,
    ST_S2A,
    ST_S2B,
    ST_T2,
    ST_L2X,
    ST_L2M,
    ST_FA,
    ST_FB,
    ST_FM1A,
    ST_FM1B,
    ST_FM1C,
    ST_FM2A,
    ST_FM2B,
    ST_FM2C,
    ST_SUM
  } state_t;

  typedef enum logic [1:0] {
    STEP_LL,
    STEP_LH,
    STEP_HL
  } mul_step_t;

  function automatic logic [63:0] rotl31(input logic [63:0] x);
    return {x[32:0], x[63:33]};
  endfunction

  function automatic logic [63:0] rotl33(input logic [63:0] x);
    return {x[30:0], x[63:31]};
  endfunction

  function automatic logic [63:0] rotl27(input logic [63:0] x);
    return {x[36:0], x[63:37]};
  endfunction

  function automatic logic [63:0] xs33(input logic [63:0] x);
    return x ^ {33'd0, x[63:33]};
  endfunction

endpackage

[rtl/m3x_mul64.sv]
// Iterative 64x64 multiplier giving the low 64 product bits over three 32x32 steps.
module m3x_mul64 (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] op_a,
  input  logic [63:0] op_b,
  output logic        done,
  output logic [63:0] product
);
  import m3x_pkg::*;

  logic [63:0] a_q;
  logic [63:0] b_q;
  logic [63:0] acc;
  mul_step_t   step;
  logic        busy;
  logic [31:0] mul_x;
  logic [31:0] mul_y;
  logic [63:0] pp;

  always_comb begin
    unique case (step)
      STEP_LL: begin
        mul_x = a_q[31:0];
        mul_y = b_q[31:0];
      end
      STEP_LH: begin
        mul_x = a_q[31:0];
        mul_y = b_q[63:32];
      end
      STEP_HL: begin
        mul_x = a_q[63:32];
        mul_y = b_q[31:0];
      end
      default: begin
        mul_x = '0;
        mul_y = '0;
      end
    endcase
  end

  assign pp = mul_x * mul_y;
  assign product = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= STEP_LL;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= STEP_LL;
      end else if (busy) begin
        unique case (step)
          STEP_LL: step <= STEP_LH;
          STEP_LH: step <= STEP_HL;
          STEP_HL: begin
            busy <= 1'b0;
            done <= 1'b1;
            step <= STEP_LL;
          end
          default: begin
            busy <= 1'b0;
            step <= STEP_LL;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_q <= op_a;
      b_q <= op_b;
    end else if (busy) begin
      unique case (step)
        STEP_LL: acc <= pp;
        STEP_LH: acc[63:32] <= acc[63:32] + pp[31:0];
        STEP_HL: acc[63:32] <= acc[63:32] + pp[31:0];
        default: acc <= acc;
      endcase
    end
  end

endmodule

[rtl/murmur3_x64_stream_hash_core.sv]
// Top level of the streaming 64-bit hash core: sequencer, lanes and config port.
//
// Usage:
//   The message arrives as beats on the item channel (item_valid/item_ready),
//   each holding two little-endian 64-bit words, a byte count and a last flag.
//   Both lanes load from seed_value at the first beat of a message. One
//   result beat (hash_value, length_overflow) leaves on the result channel
//   after each last beat.
//   Every 64-bit multiply goes through one shared 32x32 multiplier in three
//   steps; that unit sets the rate. A full beat runs from acceptance back
//   to ready through four multiplies and four lane-mix states. A short last
//   beat spends no multiply, two or four multiplies on its tail (0, 1..8 or
//   9..15 bytes); a last beat then adds finalisation with four more multiplies.
//   The result sits in an output register; the next beat is taken while it
//   waits. If the receiver stalls and a second result is due, the core holds
//   in its final step until the first result is taken.
//   Registers: seed_value at address 0 (64 bits), low_bit_mode at address 8.
//   Reset clears both registers, the message state and the result channel.
module murmur3_x64_stream_hash_core #(
  parameter int unsigned LENGTH_BITS = m3x_pkg::LENGTH_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [m3x_pkg::ADDR_W-1:0] paddr,
  input  logic [63:0]               pwdata,
  output logic [63:0]               prdata,
  output logic                      pready,
  input  logic                      item_valid,
  output logic                      item_ready,
  input  logic [63:0]               word_low,
  input  logic [63:0]               word_high,
  input  logic [4:0]                byte_count,
  input  logic                      last_block,
  output logic                      result_valid,
  input  logic                      result_ready,
  output logic [63:0]               hash_value,
  output logic                      length_overflow
);
  import m3x_pkg::*;
  `include "murmur3_x64_stream_hash_core_macros.svh"

  localparam int unsigned SUM_W = LENGTH_BITS + 1;

  state_t state;
  state_t state_next;

  logic [63:0]            seed_value;
  logic                   low_bit_mode;
  logic [63:0]            lane_one;
  logic [63:0]            lane_two;
  logic [63:0]            acc;
  logic [63:0]            w1;
  logic [63:0]            w2;
  logic [4:0]             cnt;
  logic                   last_q;
  logic [LENGTH_BITS-1:0] total_bytes;
  logic                   in_message;
  logic                   overflow_seen;
  logic                   mul_pending;

  logic                   accept;
  logic                   cfg_write;
  logic                   out_stall;
  logic                   is_mul_state;
  logic                   mul_start;
  logic                   mul_done;
  logic [63:0]            mul_a;
  logic [63:0]            mul_b;
  logic [63:0]            mul_p;
  logic [4:0]             cnt_sat;
  logic [127:0]           keep_mask;
  logic [127:0]           block_in;
  logic [LENGTH_BITS-1:0] base_total;
  logic [SUM_W-1:0]       total_sum;
  logic [63:0]            len64;

  assign accept    = item_valid && item_ready;
  assign cfg_write = psel && penable && pwrite && pready;
  assign out_stall = result_valid && !result_ready;
  assign len64     = {{(64 - LENGTH_BITS){1'b0}}, total_bytes};

  always_comb begin
    priority if (!last_block || byte_count > FULL_COUNT) begin
      cnt_sat = FULL_COUNT;
    end else begin
      cnt_sat = byte_count;
    end
  end

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      keep_mask[8*i +: 8] = (5'(i) < cnt_sat) ? 8'hff : 8'h00;
    end
    block_in = {word_high, word_low} & keep_mask;
    if (low_bit_mode) begin
      block_in = block_in & {LOW_BITS, LOW_BITS};
    end
  end

  assign base_total = in_message ? total_bytes : '0;
  assign total_sum  = {1'b0, base_total} + {{(SUM_W - 5){1'b0}}, cnt_sat};

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (item_valid) begin
          state_next = (cnt_sat == 5'd0) ? ST_FA : ST_S1A;
        end
      end
      ST_S1A: if (mul_done) state_next = ST_S1B;
      ST_S1B: if (mul_done) state_next = (cnt == FULL_COUNT) ? ST_L1X : ST_T1;
      ST_T1: begin
        priority if (cnt > HALF_COUNT) begin
          state_next = ST_S2A;
        end else if (last_q) begin
          state_next = ST_FA;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_L1X: state_next = ST_L1M;
      ST_L1M: state_next = ST_S2A;
      ST_S2A: if (mul_done) state_next = ST_S2B;
      ST_S2B: if (mul_done) state_next = (cnt == FULL_COUNT) ? ST_L2X : ST_T2;
      ST_T2:  state_next = last_q ? ST_FA : ST_IDLE;
      ST_L2X: state_next = ST_L2M;
      ST_L2M: state_next = last_q ? ST_FA : ST_IDLE;
      ST_FA:  state_next = ST_FB;
      ST_FB:  state_next = ST_FM1A;
      ST_FM1A: if (mul_done) state_next = ST_FM1B;
      ST_FM1B: if (mul_done) state_next = ST_FM1C;
      ST_FM1C: state_next = ST_FM2A;
      ST_FM2A: if (mul_done) state_next = ST_FM2B;
      ST_FM2B: if (mul_done) state_next = ST_FM2C;
      ST_FM2C: state_next = ST_SUM;
      ST_SUM: state_next = out_stall ? ST_SUM : ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    item_ready   = (state == ST_IDLE);
    is_mul_state = 1'b1;
    mul_a        = '0;
    mul_b        = '0;
    unique case (state)
      ST_S1A: begin
        mul_a = w1;
        mul_b = MUL_A;
      end
      ST_S1B: begin
        mul_a = rotl31(acc);
        mul_b = MUL_B;
      end
      ST_S2A: begin
        mul_a = w2;
        mul_b = MUL_B;
      end
      ST_S2B: begin
        mul_a = rotl33(acc);
        mul_b = MUL_A;
      end
      ST_FM1A: begin
        mul_a = xs33(lane_one);
        mul_b = FIN_A;
      end
      ST_FM1B: begin
        mul_a = xs33(acc);
        mul_b = FIN_B;
      end
      ST_FM2A: begin
        mul_a = xs33(lane_two);
        mul_b = FIN_A;
      end
      ST_FM2B: begin
        mul_a = xs33(acc);
        mul_b = FIN_B;
      end
      default: is_mul_state = 1'b0;
    endcase
    mul_start = is_mul_state && !mul_pending;
  end

  m3x_mul64 u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .op_a    (mul_a),
    .op_b    (mul_b),
    .done    (mul_done),
    .product (mul_p)
  );

  always_comb begin
    prdata = (paddr[3] == REG_MODE) ? {63'd0, low_bit_mode} : seed_value;
  end
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_value   <= '0;
      low_bit_mode <= 1'b0;
    end else if (cfg_write) begin
      if (paddr[3] == REG_SEED) begin
        seed_value <= pwdata;
      end else begin
        low_bit_mode <= pwdata[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      mul_pending   <= 1'b0;
      in_message    <= 1'b0;
      total_bytes   <= '0;
      overflow_seen <= 1'b0;
      result_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (mul_start) begin
        mul_pending <= 1'b1;
      end else if (mul_done) begin
        mul_pending <= 1'b0;
      end
      if (accept) begin
        in_message    <= 1'b1;
        total_bytes   <= total_sum[LENGTH_BITS-1:0];
        overflow_seen <= (in_message && overflow_seen) || total_sum[LENGTH_BITS];
      end else if (state == ST_SUM && !out_stall) begin
        in_message    <= 1'b0;
        total_bytes   <= '0;
        overflow_seen <= 1'b0;
      end
      if (state == ST_SUM && !out_stall) begin
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      w1     <= block_in[63:0];
      w2     <= block_in[127:64];
      cnt    <= cnt_sat;
      last_q <= last_block;
      if (!in_message) begin
        lane_one <= seed_value;
        lane_two <= seed_value;
      end
    end
    if (mul_done) begin
      acc <= mul_p;
    end
    unique case (state)
      ST_T1:   lane_one <= lane_one ^ acc;
      ST_L1X:  lane_one <= rotl27(lane_one ^ acc) + lane_two;
      ST_L1M:  lane_one <= {lane_one[61:0], 2'b00} + lane_one + ADD_ONE;
      ST_T2:   lane_two <= lane_two ^ acc;
      ST_L2X:  lane_two <= rotl31(lane_two ^ acc) + lane_one;
      ST_L2M:  lane_two <= {lane_two[61:0], 2'b00} + lane_two + ADD_TWO;
      ST_FA: begin
        lane_one <= (lane_one ^ len64) + (lane_two ^ len64);
        lane_two <= lane_two ^ len64;
      end
      ST_FB:   lane_two <= lane_two + lane_one;
      ST_FM1C: lane_one <= xs33(acc);
      ST_FM2C: lane_two <= xs33(acc);
      ST_SUM: begin
        if (!out_stall) begin
          hash_value      <= lane_one + lane_two;
          length_overflow <= overflow_seen;
        end
      end
      default: begin
      end
    endcase
  end

  `M3X_ASSERT_NOW(a_done_pending, mul_done, mul_pending, "multiplier finished without a request")
  `M3X_ASSERT_NEXT(a_accept_busy, accept, state != ST_IDLE, "accepted beat left core idle")
  `M3X_ASSERT_NOW(a_idle_total, (state == ST_IDLE) && !in_message, total_bytes == '0,
    "length not cleared between messages")

endmodule
